>>> rtl/sp3d_pkg.sv
// Shared types, constants and helper function of the stereo triangulation block.
package sp3d_pkg;

  localparam int COORD_W    = 16;
  localparam int DIM_W      = 12;
  localparam int NUM_W      = 36;
  localparam int DEN_W      = 16;
  localparam int OUT_W      = 32;
  localparam int LANES      = 3;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd3;

  localparam logic [CFG_DATA_W-1:0] FOCAL_RESET  = 16'd11968;
  localparam logic [CFG_DATA_W-1:0] BASE_RESET   = 16'd160;
  localparam logic [DIM_W-1:0]      WIDTH_RESET  = 12'd800;
  localparam logic [DIM_W-1:0]      HEIGHT_RESET = 12'd600;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  typedef logic signed [OUT_W-1:0] coord_t;

  localparam coord_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam coord_t SAT_MIN = 32'sh8000_0000;

  localparam logic [NUM_W-1:0] Q_POS_LIMIT = NUM_W'(64'h7FFF_FFFF);
  localparam logic [NUM_W-1:0] Q_NEG_LIMIT = NUM_W'(64'h8000_0000);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SAT  = 6'b001000,
    ST_BOX  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic sat;
    logic box;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  // Applies the sign to a quotient magnitude and clamps it to 32 bits.
  function automatic coord_t sat_quot(logic [NUM_W-1:0] q, logic neg, logic nzero,
                                      logic dzero);
    coord_t res;
    if (nzero) begin
      res = '0;
    end else if (dzero) begin
      res = neg ? SAT_MIN : SAT_MAX;
    end else if (neg) begin
      res = (q > Q_NEG_LIMIT) ? SAT_MIN : coord_t'(32'd0 - q[OUT_W-1:0]);
    end else begin
      res = (q > Q_POS_LIMIT) ? SAT_MAX : coord_t'(q[OUT_W-1:0]);
    end
    return res;
  endfunction

endpackage

>>> rtl/sp3d_ctrl.sv
// State machine sequencing capture, multiply, divide, clamp, box update and output.
module sp3d_ctrl import sp3d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pair_valid,
  output logic    pair_stall,
  output logic    point_valid,
  input  logic    point_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   point_valid_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    point_valid_next = point_valid && point_stall;
    unique case (state)
      ST_IDLE: begin
        if (pair_valid) begin
          cmd.load = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.sat = 1'b1;
        state_next = ST_BOX;
      end
      ST_BOX: begin
        cmd.box = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!point_valid || !point_stall) begin
          cmd.out_load = 1'b1;
          point_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign pair_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      point_valid <= 1'b0;
    end else begin
      state <= state_next;
      point_valid <= point_valid_next;
    end
  end

endmodule

>>> rtl/sp3d_datapath.sv
// Datapath: operand capture, numerator products, three-lane radix-2 divider and box.
module sp3d_datapath import sp3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [CFG_DATA_W-1:0] focal,
  input  logic [CFG_DATA_W-1:0] base,
  input  logic [DIM_W-1:0]      width,
  input  logic [DIM_W-1:0]      height,
  input  logic                  first_of_set,
  input  logic [COORD_W-1:0]    left_x,
  input  logic [COORD_W-1:0]    left_y,
  input  logic [COORD_W-1:0]    right_x,
  input  logic [COORD_W-1:0]    right_y,
  output coord_t                point_x,
  output coord_t                point_y,
  output coord_t                point_z,
  output coord_t                center_x,
  output coord_t                center_y,
  output coord_t                center_z,
  output logic [OUT_W-1:0]      extent_x,
  output logic [OUT_W-1:0]      extent_y,
  output logic [OUT_W-1:0]      extent_z,
  output logic                  zero_disparity
);

  logic                 first;
  logic                 dzero;
  logic                 d_neg;
  logic [DEN_W-1:0]     d_mag;
  logic                 dy_neg;
  logic [COORD_W:0]     dy_mag;
  logic                 dx_neg;
  logic [COORD_W-1:0]   dx_mag;
  logic [CNT_W-1:0]     cnt;
  logic [NUM_W-1:0]     acc [LANES];
  logic [DEN_W-1:0]     rem [LANES];
  logic                 nneg [LANES];
  logic                 nzero [LANES];
  coord_t               pt [LANES];
  coord_t               lo [LANES];
  coord_t               hi [LANES];

  logic signed [COORD_W:0]   d_c;
  logic [COORD_W:0]          ysum_c;
  logic signed [COORD_W+1:0] dy_c;
  logic signed [COORD_W:0]   dx_c;
  logic [2*COORD_W-1:0]      prod_z;
  logic [2*COORD_W:0]        prod_y;
  logic [2*COORD_W-1:0]      prod_x;
  logic [DEN_W:0]            sh [LANES];
  logic                      ge [LANES];
  logic [DEN_W:0]            diff [LANES];
  logic signed [OUT_W:0]     sum_c [LANES];
  coord_t                    cen_c [LANES];
  logic [OUT_W-1:0]          ext_c [LANES];

  always_comb begin
    d_c    = $signed({1'b0, left_x}) - $signed({1'b0, right_x});
    ysum_c = {1'b0, left_y} + {1'b0, right_y};
    dy_c   = $signed({1'b0, ysum_c}) - $signed({2'b00, height, 4'b0000});
    dx_c   = $signed({2'b00, width, 3'b000}) - $signed({1'b0, left_x});
    prod_z = focal * base;
    prod_y = base * dy_mag;
    prod_x = base * dx_mag;
    for (int i = 0; i < LANES; i++) begin
      sh[i]   = {rem[i], acc[i][NUM_W-1]};
      ge[i]   = (sh[i] >= {1'b0, d_mag});
      diff[i] = sh[i] - {1'b0, d_mag};
      sum_c[i] = (OUT_W+1)'(lo[i]) + (OUT_W+1)'(hi[i]);
      cen_c[i] = coord_t'(sum_c[i] >>> 1);
      ext_c[i] = OUT_W'(hi[i] - lo[i]);
    end
  end

  assign status.div_last = (cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first  <= first_of_set;
      dzero  <= (d_c == '0);
      d_neg  <= d_c[COORD_W];
      d_mag  <= d_c[COORD_W] ? DEN_W'(-d_c) : DEN_W'(d_c);
      dy_neg <= dy_c[COORD_W+1];
      dy_mag <= dy_c[COORD_W+1] ? (COORD_W+1)'(-dy_c) : (COORD_W+1)'(dy_c);
      dx_neg <= dx_c[COORD_W];
      dx_mag <= dx_c[COORD_W] ? COORD_W'(-dx_c) : COORD_W'(dx_c);
    end
    if (cmd.mul) begin
      cnt <= '0;
      acc[LANE_Z]   <= {prod_z, 4'b0000};
      acc[LANE_Y]   <= {prod_y, 3'b000};
      acc[LANE_X]   <= {prod_x, 4'b0000};
      nneg[LANE_Z]  <= 1'b1;
      nneg[LANE_Y]  <= !dy_neg;
      nneg[LANE_X]  <= !dx_neg;
      nzero[LANE_Z] <= (prod_z == '0);
      nzero[LANE_Y] <= (prod_y == '0);
      nzero[LANE_X] <= (prod_x == '0);
      for (int i = 0; i < LANES; i++) begin
        rem[i] <= '0;
      end
    end
    if (cmd.step) begin
      cnt <= cnt + 1'b1;
      for (int i = 0; i < LANES; i++) begin
        rem[i] <= ge[i] ? diff[i][DEN_W-1:0] : sh[i][DEN_W-1:0];
        acc[i] <= {acc[i][NUM_W-2:0], ge[i]};
      end
    end
    if (cmd.sat) begin
      for (int i = 0; i < LANES; i++) begin
        pt[i] <= sat_quot(acc[i], dzero ? nneg[i] : (nneg[i] ^ d_neg), nzero[i], dzero);
      end
    end
    if (cmd.out_load) begin
      point_x  <= pt[LANE_X];
      point_y  <= pt[LANE_Y];
      point_z  <= pt[LANE_Z];
      center_x <= cen_c[LANE_X];
      center_y <= cen_c[LANE_Y];
      center_z <= cen_c[LANE_Z];
      extent_x <= ext_c[LANE_X];
      extent_y <= ext_c[LANE_Y];
      extent_z <= ext_c[LANE_Z];
      zero_disparity <= dzero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        lo[i] <= SAT_MAX;
        hi[i] <= SAT_MIN;
      end
    end else if (cmd.box) begin
      for (int i = 0; i < LANES; i++) begin
        if (first || pt[i] < lo[i]) begin
          lo[i] <= pt[i];
        end
        if (first || pt[i] > hi[i]) begin
          hi[i] <= pt[i];
        end
      end
    end
  end

endmodule

>>> rtl/stereo_pair_to_3d_point.sv
// Top level of the stereo pair to 3D point block with configuration registers.
// A pair passes the multiply, divide, clamp and box states before its result beat is offered.
// No new pair is taken until the last result is loaded; a stalled result beat delays that.
// Three 36-step radix-2 dividers, one per x, y and z lane, run side by side.
// Synchronous reset restores the register defaults and empties the bounding box.
// Configuration writes are taken in every cycle.
module stereo_pair_to_3d_point import sp3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pair_valid,
  output logic                  pair_stall,
  input  logic                  first_of_set,
  input  logic [COORD_W-1:0]    left_x,
  input  logic [COORD_W-1:0]    left_y,
  input  logic [COORD_W-1:0]    right_x,
  input  logic [COORD_W-1:0]    right_y,
  output logic                  point_valid,
  input  logic                  point_stall,
  output coord_t                point_x,
  output coord_t                point_y,
  output coord_t                point_z,
  output coord_t                center_x,
  output coord_t                center_y,
  output coord_t                center_z,
  output logic [OUT_W-1:0]      extent_x,
  output logic [OUT_W-1:0]      extent_y,
  output logic [OUT_W-1:0]      extent_z,
  output logic                  zero_disparity
);

  logic [CFG_DATA_W-1:0] focal;
  logic [CFG_DATA_W-1:0] base;
  logic [DIM_W-1:0]      width;
  logic [DIM_W-1:0]      height;
  cmd_t                  cmd;
  status_t               status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal  <= FOCAL_RESET;
      base   <= BASE_RESET;
      width  <= WIDTH_RESET;
      height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FOCAL:  focal  <= cfg_data;
        CFG_BASE:   base   <= cfg_data;
        CFG_WIDTH:  width  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sp3d_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .status      (status),
    .cmd         (cmd)
  );

  sp3d_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .focal          (focal),
    .base           (base),
    .width          (width),
    .height         (height),
    .first_of_set   (first_of_set),
    .left_x         (left_x),
    .left_y         (left_y),
    .right_x        (right_x),
    .right_y        (right_y),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .extent_x       (extent_x),
    .extent_y       (extent_y),
    .extent_z       (extent_z),
    .zero_disparity (zero_disparity)
  );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the stereo pair to 3D point block with its bounding box.
module testbench import sp3d_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd13;
  localparam int ROWS = 19;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic               first;
    logic [COORD_W-1:0] lx;
    logic [COORD_W-1:0] ly;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
  } pair_t;

  typedef struct packed {
    logic [0:LANES-1][OUT_W-1:0] pos;
    logic [0:LANES-1][OUT_W-1:0] mid;
    logic [0:LANES-1][OUT_W-1:0] span;
    logic                        zd;
  } point_t;

  typedef struct packed {
    logic   typed;
    point_t want;
  } check_t;

  typedef struct packed {
    logic               first;
    logic [COORD_W-1:0] lx;
    logic [COORD_W-1:0] ly;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic               typed;
    coord_t             px;
    coord_t             py;
    coord_t             pz;
    logic               zd;
  } row_t;

  // Typed rows hold a single point in the box, so center equals the point and size is zero.
  row_t plan [ROWS] = '{
    '{1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, SAT_MIN, SAT_MAX, SAT_MIN, 1'b1},
    '{1'b1, 16'd6400,  16'd4800,  16'd6384,  16'd4800,  1'b1, 32'sd0, 32'sd0,
      -32'sd1914880, 1'b0},
    '{1'b1, 16'd6400,  16'd4800,  16'd6400,  16'd4800,  1'b1, 32'sd0, 32'sd0, SAT_MIN, 1'b1},
    '{1'b0, 16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b1, 16'd65535, 16'd0,     16'd0,     16'd0,     1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd0,     16'd65535, 16'd65535, 16'd65535, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd1,     16'd4800,  16'd0,     16'd4800,  1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd0,     16'd4800,  16'd1,     16'd4800,  1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b1, 16'd6400,  16'd0,     16'd6399,  16'd65535, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd65535, 16'd0,     16'd65534, 16'd0,     1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd12345, 16'd23456, 16'd11345, 16'd22456, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b1, 16'd3200,  16'd1000,  16'd3000,  16'd1010,  1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd9600,  16'd8000,  16'd9400,  16'd7990,  1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd4000,  16'd4800,  16'd3990,  16'd4800,  1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd30000, 16'd40000, 16'd29990, 16'd40000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b1, 16'd40000, 16'd2000,  16'd40100, 16'd2100,  1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd43690, 16'd21845, 16'd43680, 16'd21845, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
    '{1'b0, 16'd21845, 16'd43690, 16'd21835, 16'd43690, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0}
  };

  string axis [LANES] = '{"x", "y", "z"};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  pair_valid;
  logic                  pair_stall;
  logic                  first_of_set;
  logic [COORD_W-1:0]    left_x;
  logic [COORD_W-1:0]    left_y;
  logic [COORD_W-1:0]    right_x;
  logic [COORD_W-1:0]    right_y;
  logic                  point_valid;
  logic                  point_stall;
  coord_t                point_x;
  coord_t                point_y;
  coord_t                point_z;
  coord_t                center_x;
  coord_t                center_y;
  coord_t                center_z;
  logic [OUT_W-1:0]      extent_x;
  logic [OUT_W-1:0]      extent_y;
  logic [OUT_W-1:0]      extent_z;
  logic                  zero_disparity;

  logic [15:0] focal_q4;
  logic [15:0] base_mm;
  logic [11:0] width_px;
  logic [11:0] height_px;
  coord_t      box_lo [LANES];
  coord_t      box_hi [LANES];

  point_t expected_points [$];
  check_t hand_checked [$];

  bit calm = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int pairs_taken = 0;
  int zero_hits = 0;
  int restarts = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  stereo_pair_to_3d_point dut (.*);

  always #4 clk = ~clk;

  function automatic coord_t clamp_quotient(longint num, longint den);
    longint q;
    if (den == 0) begin
      return (num > 0) ? SAT_MAX : (num < 0) ? SAT_MIN : coord_t'(0);
    end
    q = num / den;
    if (q > longint'(SAT_MAX)) return SAT_MAX;
    if (q < longint'(SAT_MIN)) return SAT_MIN;
    return coord_t'(q);
  endfunction

  // Triangulates one pair with the current registers and folds it into the box.
  function automatic point_t triangulate(pair_t p);
    point_t r;
    longint f, b, w, h, d, s;
    coord_t pt [LANES];
    f = longint'(focal_q4);
    b = longint'(base_mm);
    w = longint'(width_px);
    h = longint'(height_px);
    d = longint'(p.lx) - longint'(p.rx);
    pt[LANE_X] = clamp_quotient(-(16 * b * (8 * w - longint'(p.lx))), d);
    pt[LANE_Y] = clamp_quotient(-(8 * b * ((longint'(p.ly) + longint'(p.ry)) - 16 * h)), d);
    pt[LANE_Z] = clamp_quotient(-(16 * f * b), d);
    for (int a = 0; a < LANES; a++) begin
      if (p.first) begin
        box_lo[a] = SAT_MAX;
        box_hi[a] = SAT_MIN;
      end
      if (pt[a] < box_lo[a]) box_lo[a] = pt[a];
      if (pt[a] > box_hi[a]) box_hi[a] = pt[a];
      s = longint'(box_lo[a]) + longint'(box_hi[a]);
      r.pos[a] = pt[a];
      r.mid[a] = OUT_W'(s >>> 1);
      r.span[a] = OUT_W'(longint'(box_hi[a]) - longint'(box_lo[a]));
    end
    r.zd = (d == 0);
    return r;
  endfunction

  function automatic logic [15:0] to_q4(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // Random pairs: mostly small or moderate disparity, rows near the image center half of the time.
  function automatic pair_t random_pair(bit first);
    pair_t p;
    int lx, rx, d, cy;
    lx = ($urandom_range(0, 3) == 0) ? 8 * int'(width_px) + $urandom_range(0, 63) - 32
                                     : $urandom_range(0, 65535);
    lx = int'(to_q4(lx));
    case ($urandom_range(0, 7))
      0:       d = 0;
      1, 2, 3: d = $urandom_range(1, 64);
      4, 5:    d = $urandom_range(65, 4096);
      default: d = lx - $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 1)) d = -d;
    rx = lx - d;
    if (rx < 0 || rx > 65535) rx = lx + d;
    cy = 8 * int'(height_px);
    p.first = first;
    p.lx = 16'(lx);
    p.rx = to_q4(rx);
    p.ly = $urandom_range(0, 1) ? to_q4(cy + $urandom_range(0, 511) - 256)
                                : 16'($urandom_range(0, 65535));
    p.ry = $urandom_range(0, 2) != 0 ? to_q4(int'(p.ly) + $urandom_range(0, 31) - 16)
                                     : 16'($urandom_range(0, 65535));
    return p;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch on result beat %0d: %s is %h, expected %h", results_seen, what, got,
             want);
  endtask

  always @(posedge clk) begin
    check_t stamp;
    pair_t  seen;
    point_t forecast;
    if (rst) begin
      focal_q4 = FOCAL_RESET;
      base_mm = BASE_RESET;
      width_px = WIDTH_RESET;
      height_px = HEIGHT_RESET;
      for (int a = 0; a < LANES; a++) begin
        box_lo[a] = SAT_MAX;
        box_hi[a] = SAT_MIN;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FOCAL:  focal_q4 = cfg_data;
          CFG_BASE:   base_mm = cfg_data;
          CFG_WIDTH:  width_px = cfg_data[DIM_W-1:0];
          CFG_HEIGHT: height_px = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (pair_valid && !pair_stall) begin
        seen = '{first_of_set, left_x, left_y, right_x, right_y};
        forecast = triangulate(seen);
        stamp = hand_checked.pop_front();
        expected_points.insert(expected_points.size(), stamp.typed ? stamp.want : forecast);
        pairs_taken++;
        if (forecast.zd) zero_hits++;
        if (seen.first) restarts++;
      end
    end
  end

  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (!rst && point_valid && !point_stall) begin
      results_seen++;
      got.pos = {point_x, point_y, point_z};
      got.mid = {center_x, center_y, center_z};
      got.span = {extent_x, extent_y, extent_z};
      got.zd = zero_disparity;
      if (expected_points.size() == 0) begin
        flag_mismatch("beat with nothing expected, point_x", got.pos[LANE_X], '0);
      end else begin
        want = expected_points.pop_front();
        for (int a = 0; a < LANES; a++) begin
          if (got.pos[a] !== want.pos[a])
            flag_mismatch({"point_", axis[a]}, got.pos[a], want.pos[a]);
          if (got.mid[a] !== want.mid[a])
            flag_mismatch({"center_", axis[a]}, got.mid[a], want.mid[a]);
          if (got.span[a] !== want.span[a])
            flag_mismatch({"extent_", axis[a]}, got.span[a], want.span[a]);
        end
        if (got.zd !== want.zd) flag_mismatch("zero_disparity", 32'(got.zd), 32'(want.zd));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pair_valid && !pair_stall) || (point_valid && !point_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_stall
    bit hold;
    point_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        point_stall <= 1'b0;
      end else begin
        hold = ($urandom_range(0, 2) == 0);
        point_stall <= hold;
        repeat ((hold ? $urandom_range(1, 10) : $urandom_range(1, 40)) - 1) @(negedge clk);
      end
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic load_settings(logic [15:0] f, logic [15:0] b, logic [15:0] w,
                               logic [15:0] h);
    write_register(CFG_FOCAL, f);
    write_register(CFG_BASE, b);
    write_register(CFG_WIDTH, w);
    write_register(CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic offer_pair(pair_t p, bit typed, point_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      pair_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    hand_checked.insert(hand_checked.size(), check_t'{typed, want});
    pair_valid <= 1'b1;
    first_of_set <= p.first;
    left_x <= p.lx;
    left_y <= p.ly;
    right_x <= p.rx;
    right_y <= p.ry;
    forever begin
      @(posedge clk);
      if (!pair_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_points.size() != 0 || hand_checked.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    pair_t       p;
    point_t      want;
    int          quota;
    logic [15:0] f, b, w, h;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pair_valid = 1'b0;
    first_of_set = 1'b0;
    left_x = '0;
    left_y = '0;
    right_x = '0;
    right_y = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      p = '{plan[r].first, plan[r].lx, plan[r].ly, plan[r].rx, plan[r].ry};
      want.pos = {plan[r].px, plan[r].py, plan[r].pz};
      want.mid = want.pos;
      want.span = '0;
      want.zd = plan[r].zd;
      offer_pair(p, plan[r].typed, want);
    end
    pair_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: {f, b, w, h} = {16'd65535, 16'd65535, 16'd4095, 16'd4095};
        1: {f, b, w, h} = {16'd1, 16'd1, 16'd1, 16'd1};
        2: {f, b, w, h} = {16'd0, 16'd160, 16'd800, 16'd600};
        3: {f, b, w, h} = {16'd11968, 16'd0, 16'd800, 16'd600};
        default: begin
          f = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                   : 16'($urandom_range(4000, 20000));
          b = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                   : 16'($urandom_range(50, 400));
          w = 16'($urandom_range(1, 4095));
          h = 16'($urandom_range(1, 4095));
          if (ph % 2 == 1) begin
            w = w | (16'($urandom_range(1, 15)) << 12);
            h = h | (16'($urandom_range(1, 15)) << 12);
          end
        end
      endcase
      if (ph == 4) write_register(CFG_SPARE, 16'($urandom));
      load_settings(f, b, w, h);
      quota = (ph < 2) ? 60 : (ph < 4) ? 40 : 75;
      for (int k = 0; k < quota; k++) begin
        if (ph == 9 && quota - k <= 60) calm = 1'b1;
        p = random_pair(k == 0 || $urandom_range(0, 7) == 0);
        offer_pair(p, 1'b0, '0);
      end
      pair_valid <= 1'b0;
      drain();
    end

    repeat (50) @(posedge clk);
    $display("run: %0d point pairs under %0d register settings, %0d with zero disparity,",
             pairs_taken, settings_used, zero_hits);
    $display("run: %0d box restarts, %0d result beats checked, %0d mismatches", restarts,
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
